### design/assert_macros.svh
// Assertion macros used by the checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every enabled clock edge.
`define MPA_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the following cycle.
`define MPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mpa_pkg.sv
// Shared types, constants and codes of the multi-pattern automaton.
// Depends on nothing; used by the sequencer, the top level and the checker.
`default_nettype none

package mpa_pkg;

    localparam int MAX_NODES    = 128;
    localparam int MAX_PATTERNS = 8;
    localparam int ALPHABET     = 26;

    localparam int NODE_W = 7;
    localparam int CNT_W  = 8;
    localparam int LET_W  = 5;
    localparam int CA_W   = NODE_W + LET_W;
    localparam int CA_DEPTH = 2 ** CA_W;

    typedef logic [NODE_W-1:0]       t_node;
    typedef logic [CNT_W-1:0]        t_count;
    typedef logic [LET_W-1:0]        t_letter;
    typedef logic [MAX_PATTERNS-1:0] t_mask;
    typedef logic [CA_W-1:0]         t_caddr;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_BUILD   = 3'd1;
    localparam logic [2:0] OP_SCAN    = 3'd2;
    localparam logic [2:0] OP_RESTART = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_NOBUILD = 2'd2;

    typedef struct packed {
        logic [2:0] opcode;
        t_letter    letter;
        logic [2:0] pattern_index;
        logic       end_of_pattern;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        t_node      current_node;
        t_mask      found_patterns;
        t_count     node_total;
    } t_out_word;

    // Port bundles toward the table memories.
    typedef struct packed {
        logic   we;
        t_caddr waddr;
        t_node  wdata;
        t_caddr raddr;
    } t_tab_port;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_node wdata;
        t_node raddr;
    } t_node_port;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_mask wdata;
        t_node raddr;
    } t_mask_port;

    typedef enum logic [4:0] {
        SQ_CLR,
        SQ_IDLE,
        SQ_I_RD,
        SQ_I_CHK,
        SQ_I_OWN,
        SQ_I_CLR,
        SQ_B_INIT0,
        SQ_B_INIT1,
        SQ_B_POP,
        SQ_B_U,
        SQ_B_F,
        SQ_B_CH,
        SQ_B_CV,
        SQ_B_MASK,
        SQ_S_RD,
        SQ_S_G,
        SQ_S_M,
        SQ_RESP
    } t_state;

endpackage

`default_nettype wire

### design/mpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module mpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### design/mpa_seq.sv
// Sequencer of the automaton: insert, breadth-first build, scan, restart and clear.
// Depends on mpa_pkg; drives the table memories held in the top level.
`default_nettype none

module mpa_seq
    import mpa_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_start,
    input  wire t_in_word   i_word,
    output logic            o_ready,
    output logic            o_res_valid,
    output t_out_word       o_result,
    input  wire logic       i_res_take,
    output t_tab_port       o_child,
    input  wire t_node      i_child_q,
    output t_tab_port       o_goto,
    input  wire t_node      i_goto_q,
    output t_node_port      o_fail,
    input  wire t_node      i_fail_q,
    output t_node_port      o_queue,
    input  wire t_node      i_queue_q,
    output t_mask_port      o_own,
    input  wire t_mask      i_own_q,
    output t_mask_port      o_outm,
    input  wire t_mask      i_outm_q
);

    localparam t_letter LAST_LETTER = t_letter'(ALPHABET - 1);

    t_state     r_state, n_state;
    t_node      r_cursor, n_cursor;
    t_node      r_scan, n_scan;
    t_mask      r_seen, n_seen;
    t_count     r_nodes, n_nodes;
    logic       r_built, n_built;
    t_count     r_head, n_head;
    t_count     r_tail, n_tail;
    t_letter    r_k, n_k;
    logic       r_clr_resp, n_clr_resp;
    t_in_word   r_in, n_in;
    logic [1:0] r_status, n_status;
    t_node      r_u, n_u;
    t_node      r_f, n_f;
    t_node      r_v, n_v;
    t_node      r_nxt, n_nxt;

    logic  w_pvalid;
    t_mask w_pbit;
    t_node w_g;

    assign w_pvalid = r_in.end_of_pattern && (32'(r_in.pattern_index) < MAX_PATTERNS);
    assign w_pbit   = t_mask'(1) << r_in.pattern_index;
    assign w_g      = (r_u == '0) ? '0 : i_goto_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= SQ_CLR;
            r_cursor   <= '0;
            r_scan     <= '0;
            r_seen     <= '0;
            r_nodes    <= t_count'(1);
            r_built    <= 1'b0;
            r_head     <= '0;
            r_tail     <= '0;
            r_k        <= '0;
            r_clr_resp <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cursor   <= n_cursor;
            r_scan     <= n_scan;
            r_seen     <= n_seen;
            r_nodes    <= n_nodes;
            r_built    <= n_built;
            r_head     <= n_head;
            r_tail     <= n_tail;
            r_k        <= n_k;
            r_clr_resp <= n_clr_resp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_status <= n_status;
        r_u      <= n_u;
        r_f      <= n_f;
        r_v      <= n_v;
        r_nxt    <= n_nxt;
    end

    // Advance to the next letter of the current node, or pop the next node.
    function automatic t_state next_letter_state(input t_letter k);
        return (k == LAST_LETTER) ? SQ_B_POP : SQ_B_CH;
    endfunction

    always_comb begin
        n_state    = r_state;
        n_cursor   = r_cursor;
        n_scan     = r_scan;
        n_seen     = r_seen;
        n_nodes    = r_nodes;
        n_built    = r_built;
        n_head     = r_head;
        n_tail     = r_tail;
        n_k        = r_k;
        n_clr_resp = r_clr_resp;
        n_in       = r_in;
        n_status   = r_status;
        n_u        = r_u;
        n_f        = r_f;
        n_v        = r_v;
        n_nxt      = r_nxt;

        o_child = '0;
        o_goto  = '0;
        o_fail  = '0;
        o_queue = '0;
        o_own   = '0;
        o_outm  = '0;

        case (r_state)
            SQ_CLR: begin
                // Clear the root row and the root's own mask.
                o_child.we    = 1'b1;
                o_child.waddr = {t_node'(0), r_k};
                o_own.we      = 1'b1;
                o_own.waddr   = '0;
                if (r_k == LAST_LETTER) begin
                    n_k     = '0;
                    n_state = r_clr_resp ? SQ_RESP : SQ_IDLE;
                end else begin
                    n_k = r_k + t_letter'(1);
                end
            end

            SQ_IDLE: begin
                if (i_start) begin
                    n_in     = i_word;
                    n_status = ST_OK;
                    case (i_word.opcode)
                        OP_INSERT: begin
                            n_state = (32'(i_word.letter) < ALPHABET) ? SQ_I_RD : SQ_RESP;
                        end
                        OP_BUILD: begin
                            n_state = SQ_B_INIT0;
                        end
                        OP_SCAN: begin
                            if (!r_built) begin
                                n_status = ST_NOBUILD;
                                n_state  = SQ_RESP;
                            end else if (32'(i_word.letter) < ALPHABET) begin
                                n_state = SQ_S_RD;
                            end else begin
                                n_scan  = '0;
                                n_state = SQ_RESP;
                            end
                        end
                        OP_RESTART: begin
                            n_scan  = '0;
                            n_seen  = '0;
                            n_state = SQ_RESP;
                        end
                        OP_CLEAR: begin
                            n_cursor   = '0;
                            n_scan     = '0;
                            n_seen     = '0;
                            n_nodes    = t_count'(1);
                            n_built    = 1'b0;
                            n_k        = '0;
                            n_clr_resp = 1'b1;
                            n_state    = SQ_CLR;
                        end
                        default: begin
                            n_state = SQ_RESP;
                        end
                    endcase
                end
            end

            SQ_I_RD: begin
                o_child.raddr = {r_cursor, r_in.letter};
                n_state       = SQ_I_CHK;
            end

            SQ_I_CHK: begin
                n_built = 1'b0;
                if (i_child_q != '0) begin
                    n_cursor = r_in.end_of_pattern ? '0 : i_child_q;
                    n_nxt    = i_child_q;
                    o_own.raddr = i_child_q;
                    n_state  = w_pvalid ? SQ_I_OWN : SQ_RESP;
                end else if (r_nodes >= t_count'(MAX_NODES)) begin
                    n_status = ST_FULL;
                    if (r_in.end_of_pattern) begin
                        n_cursor = '0;
                    end
                    n_state = SQ_RESP;
                end else begin
                    n_nxt         = r_nodes[NODE_W-1:0];
                    n_nodes       = r_nodes + t_count'(1);
                    o_child.we    = 1'b1;
                    o_child.waddr = {r_cursor, r_in.letter};
                    o_child.wdata = r_nodes[NODE_W-1:0];
                    o_own.we      = 1'b1;
                    o_own.waddr   = r_nodes[NODE_W-1:0];
                    o_own.wdata   = w_pvalid ? w_pbit : '0;
                    n_cursor      = r_in.end_of_pattern ? '0 : r_nodes[NODE_W-1:0];
                    n_k           = '0;
                    n_state       = SQ_I_CLR;
                end
            end

            SQ_I_OWN: begin
                o_own.we    = 1'b1;
                o_own.waddr = r_nxt;
                o_own.wdata = i_own_q | w_pbit;
                n_state     = SQ_RESP;
            end

            SQ_I_CLR: begin
                // Wipe the child row of the new node.
                o_child.we    = 1'b1;
                o_child.waddr = {r_nxt, r_k};
                if (r_k == LAST_LETTER) begin
                    n_k     = '0;
                    n_state = SQ_RESP;
                end else begin
                    n_k = r_k + t_letter'(1);
                end
            end

            SQ_B_INIT0: begin
                o_own.raddr = '0;
                n_state     = SQ_B_INIT1;
            end

            SQ_B_INIT1: begin
                o_outm.we    = 1'b1;
                o_outm.waddr = '0;
                o_outm.wdata = i_own_q;
                o_queue.we   = 1'b1;
                o_fail.we    = 1'b1;
                n_head       = '0;
                n_tail       = t_count'(1);
                n_state      = SQ_B_POP;
            end

            SQ_B_POP: begin
                if (r_head == r_tail) begin
                    n_built = 1'b1;
                    n_scan  = '0;
                    n_seen  = '0;
                    n_state = SQ_RESP;
                end else begin
                    o_queue.raddr = r_head[NODE_W-1:0];
                    n_head        = r_head + t_count'(1);
                    n_state       = SQ_B_U;
                end
            end

            SQ_B_U: begin
                n_u          = i_queue_q;
                o_fail.raddr = i_queue_q;
                n_k          = '0;
                n_state      = SQ_B_F;
            end

            SQ_B_F: begin
                n_f     = i_fail_q;
                n_state = SQ_B_CH;
            end

            SQ_B_CH: begin
                o_child.raddr = {r_u, r_k};
                o_goto.raddr  = {r_f, r_k};
                n_state       = SQ_B_CV;
            end

            SQ_B_CV: begin
                o_goto.we    = 1'b1;
                o_goto.waddr = {r_u, r_k};
                if (i_child_q != '0) begin
                    o_goto.wdata = i_child_q;
                    o_fail.we    = 1'b1;
                    o_fail.waddr = i_child_q;
                    o_fail.wdata = w_g;
                    if (r_tail < t_count'(MAX_NODES)) begin
                        o_queue.we    = 1'b1;
                        o_queue.waddr = r_tail[NODE_W-1:0];
                        o_queue.wdata = i_child_q;
                        n_tail        = r_tail + t_count'(1);
                    end
                    o_own.raddr  = i_child_q;
                    o_outm.raddr = w_g;
                    n_v          = i_child_q;
                    n_state      = SQ_B_MASK;
                end else begin
                    o_goto.wdata = w_g;
                    n_k          = r_k + t_letter'(1);
                    n_state      = next_letter_state(r_k);
                end
            end

            SQ_B_MASK: begin
                o_outm.we    = 1'b1;
                o_outm.waddr = r_v;
                o_outm.wdata = i_own_q | i_outm_q;
                n_k          = r_k + t_letter'(1);
                n_state      = next_letter_state(r_k);
            end

            SQ_S_RD: begin
                o_goto.raddr = {r_scan, r_in.letter};
                n_state      = SQ_S_G;
            end

            SQ_S_G: begin
                n_scan       = i_goto_q;
                o_outm.raddr = i_goto_q;
                n_state      = SQ_S_M;
            end

            SQ_S_M: begin
                n_seen  = r_seen | i_outm_q;
                n_state = SQ_RESP;
            end

            SQ_RESP: begin
                if (i_res_take) begin
                    n_clr_resp = 1'b0;
                    n_state    = SQ_IDLE;
                end
            end

            default: begin
                n_state = SQ_IDLE;
            end
        endcase
    end

    assign o_ready     = (r_state == SQ_IDLE);
    assign o_res_valid = (r_state == SQ_RESP);

    always_comb begin
        o_result.status         = r_status;
        o_result.current_node   = (r_in.opcode == OP_INSERT) ? r_cursor : r_scan;
        o_result.found_patterns = r_seen;
        o_result.node_total     = r_nodes;
    end

endmodule

`default_nettype wire

### design/multi_pattern_automaton_unit.sv
// Top level of the multi-pattern automaton: table memories, sequencer, result register.
// Depends on mpa_pkg, mpa_ram and mpa_seq.
// Usage:
//   Input channel: i_in_valid / o_in_stall / i_in_word carry one command word
//   (insert letter, build, scan letter, restart scan, clear all). A word is
//   taken on a clock edge with i_in_valid high and o_in_stall low.
//   Output channel: o_out_valid / i_out_stall / o_out_word return exactly one
//   result word per command: status, node after the step, found set, node count.
//   Steps per command, from accept to result in the output register:
//     restart, unused codes, scan before build: straight to the result
//     scan letter: goto read, then output mask read
//     insert on an existing child: child read, then own mask update at pattern end
//     insert that allocates a node: child read, then wipe of the new row
//     clear all: wipe of the root row
//     build: all letters of every node walked, node by node in breadth-first order
//   One command is in flight at a time; the next is taken once the result has
//   moved to the output register, so a waiting result does not block input.
//   Reset: synchronous, active low. After release the block wipes the root
//   row letter by letter with o_in_stall high, then accepts words.
//   Output stall: the result word holds until taken; the sequencer waits.
`default_nettype none

module multi_pattern_automaton_unit
    import mpa_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    logic       w_ready;
    logic       w_start;
    logic       w_res_valid;
    logic       w_take;
    t_out_word  w_result;

    t_tab_port  w_child, w_goto;
    t_node_port w_fail, w_queue;
    t_mask_port w_own, w_outm;
    t_node      w_child_q, w_goto_q, w_fail_q, w_queue_q;
    t_mask      w_own_q, w_outm_q;

    logic       r_ov;
    t_out_word  r_out;

    // Take a command only while the sequencer sits idle.
    assign o_in_stall = !w_ready;
    assign w_start    = i_in_valid && w_ready;

    // Move a finished result into the output register when it is free or draining.
    assign w_take = w_res_valid && (!r_ov || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_take) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    mpa_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_word      (i_in_word),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_result    (w_result),
        .i_res_take  (w_take),
        .o_child     (w_child),
        .i_child_q   (w_child_q),
        .o_goto      (w_goto),
        .i_goto_q    (w_goto_q),
        .o_fail      (w_fail),
        .i_fail_q    (w_fail_q),
        .o_queue     (w_queue),
        .i_queue_q   (w_queue_q),
        .o_own       (w_own),
        .i_own_q     (w_own_q),
        .o_outm      (w_outm),
        .i_outm_q    (w_outm_q)
    );

    // Trie children, row per node, 32 letter slots per row.
    mpa_ram #(.WIDTH(NODE_W), .DEPTH(CA_DEPTH)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (w_child.we),
        .i_waddr (w_child.waddr),
        .i_wdata (w_child.wdata),
        .i_raddr (w_child.raddr),
        .o_rdata (w_child_q)
    );

    // Complete goto table filled by the build.
    mpa_ram #(.WIDTH(NODE_W), .DEPTH(CA_DEPTH)) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (w_goto.we),
        .i_waddr (w_goto.waddr),
        .i_wdata (w_goto.wdata),
        .i_raddr (w_goto.raddr),
        .o_rdata (w_goto_q)
    );

    mpa_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_fail_ram (
        .i_clk   (i_clk),
        .i_we    (w_fail.we),
        .i_waddr (w_fail.waddr),
        .i_wdata (w_fail.wdata),
        .i_raddr (w_fail.raddr),
        .o_rdata (w_fail_q)
    );

    // Breadth-first work queue of the build.
    mpa_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (w_queue.we),
        .i_waddr (w_queue.waddr),
        .i_wdata (w_queue.wdata),
        .i_raddr (w_queue.raddr),
        .o_rdata (w_queue_q)
    );

    mpa_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_own_ram (
        .i_clk   (i_clk),
        .i_we    (w_own.we),
        .i_waddr (w_own.waddr),
        .i_wdata (w_own.wdata),
        .i_raddr (w_own.raddr),
        .o_rdata (w_own_q)
    );

    mpa_ram #(.WIDTH(MAX_PATTERNS), .DEPTH(MAX_NODES)) u_outm_ram (
        .i_clk   (i_clk),
        .i_we    (w_outm.we),
        .i_waddr (w_outm.waddr),
        .i_wdata (w_outm.wdata),
        .i_raddr (w_outm.raddr),
        .o_rdata (w_outm_q)
    );

endmodule

`default_nettype wire

### design/mpa_checker.sv
// Port-level checker of the multi-pattern automaton, bound to the top level.
// Depends on mpa_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module mpa_checker
    import mpa_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    `MPA_ASSERT_ALWAYS(a_status_code, i_clk, i_rst_n, !o_out_valid || (o_out_word.status == ST_OK) || (o_out_word.status == ST_FULL) || (o_out_word.status == ST_NOBUILD), "bad status code")

    `MPA_ASSERT_ALWAYS(a_node_total, i_clk, i_rst_n, !o_out_valid || ((o_out_word.node_total != '0) && (o_out_word.node_total <= t_count'(MAX_NODES))), "node count out of range")

    `MPA_ASSERT_ALWAYS(a_node_in_use, i_clk, i_rst_n, !o_out_valid || ({1'b0, o_out_word.current_node} < o_out_word.node_total), "reported node not in use")

    `MPA_ASSERT_NEXT(a_hold_word, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result word changed")

endmodule

bind multi_pattern_automaton_unit mpa_checker u_mpa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire

### verif/tb_multi_pattern_automaton_unit.sv
// Self-checking testbench for multi_pattern_automaton_unit: pattern insert, build, scan.
// Depends on mpa_pkg and the block's RTL; predicts every result word in place.
`timescale 1ns / 100ps
`default_nettype none

module tb_multi_pattern_automaton_unit;
    import mpa_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_word;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_word;

    multi_pattern_automaton_unit u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    // Predictor state: a shadow copy of the tables.
    int unsigned trie_child [MAX_NODES*ALPHABET];
    int unsigned goto_next  [MAX_NODES*ALPHABET];
    int unsigned fail_node  [MAX_NODES];
    t_mask       node_own   [MAX_NODES];
    t_mask       node_out   [MAX_NODES];
    int unsigned node_count;
    int unsigned ins_cursor;
    int unsigned scan_pos;
    t_mask       found_set;
    bit          built;

    t_out_word   pending_results[$];
    int unsigned err_count;
    int unsigned cycle_count;
    int unsigned results_seen;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Abort on a hung handshake.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("** multi_pattern_automaton_unit: FAILED **");
            $finish;
        end
    end

    function automatic void clear_model();
        for (int i = 0; i < MAX_NODES*ALPHABET; i++) begin
            trie_child[i] = 0;
            goto_next[i]  = 0;
        end
        for (int i = 0; i < MAX_NODES; i++) begin
            fail_node[i] = 0;
            node_own[i]  = '0;
            node_out[i]  = '0;
        end
        node_count = 1;
        ins_cursor = 0;
        scan_pos   = 0;
        found_set  = '0;
        built      = 1'b0;
    endfunction

    // Breadth-first walk: failure links, output masks, full goto rows.
    function automatic void build_goto();
        int unsigned fifo[$];
        int unsigned u, f, v, fv;
        fifo = {fifo, 0};
        fail_node[0] = 0;
        node_out[0]  = node_own[0];
        while (fifo.size() > 0) begin
            u = fifo.pop_front();
            f = fail_node[u];
            for (int c = 0; c < ALPHABET; c++) begin
                v = trie_child[u*ALPHABET + c];
                if (v != 0) begin
                    fv = (u == 0) ? 0 : goto_next[f*ALPHABET + c];
                    fail_node[v] = fv;
                    node_out[v]  = node_own[v] | node_out[fv];
                    goto_next[u*ALPHABET + c] = v;
                    fifo = {fifo, v};
                end else begin
                    goto_next[u*ALPHABET + c] = (u == 0) ? 0 : goto_next[f*ALPHABET + c];
                end
            end
        end
        built     = 1'b1;
        scan_pos  = 0;
        found_set = '0;
    endfunction

    function automatic t_out_word predict_word(t_in_word w);
        t_out_word   r;
        int unsigned slot, nxt;
        bit          ok;
        r = '0;
        r.status = ST_OK;
        case (w.opcode)
            OP_INSERT: begin
                if (w.letter < ALPHABET) begin
                    slot = ins_cursor*ALPHABET + w.letter;
                    nxt  = trie_child[slot];
                    ok   = 1'b1;
                    if (nxt == 0) begin
                        if (node_count >= MAX_NODES) begin
                            ok = 1'b0;
                            r.status = ST_FULL;
                        end else begin
                            nxt = node_count;
                            node_count++;
                            for (int c = 0; c < ALPHABET; c++)
                                trie_child[nxt*ALPHABET + c] = 0;
                            node_own[nxt] = '0;
                            trie_child[slot] = nxt;
                        end
                    end
                    built = 1'b0;
                    if (ok) begin
                        ins_cursor = nxt;
                        if (w.end_of_pattern)
                            node_own[nxt][w.pattern_index] = 1'b1;
                    end
                    if (w.end_of_pattern)
                        ins_cursor = 0;
                end
            end
            OP_BUILD: build_goto();
            OP_SCAN: begin
                if (!built) begin
                    r.status = ST_NOBUILD;
                end else if (w.letter < ALPHABET) begin
                    scan_pos  = goto_next[scan_pos*ALPHABET + w.letter];
                    found_set = found_set | node_out[scan_pos];
                end else begin
                    scan_pos = 0;
                end
            end
            OP_RESTART: begin
                scan_pos  = 0;
                found_set = '0;
            end
            OP_CLEAR: clear_model();
            default: ;
        endcase
        r.current_node   = t_node'((w.opcode == OP_INSERT) ? ins_cursor : scan_pos);
        r.found_patterns = found_set;
        r.node_total     = t_count'(node_count);
        return r;
    endfunction

    // Send one command word after a random gap; predict on acceptance.
    // Drop valid only when a gap follows, so valid gets one update per edge.
    task automatic send_word(t_in_word w);
        int unsigned gap;
        gap = (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11));
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        pending_results = {pending_results, predict_word(w)};
    endtask

    function automatic t_in_word make_word(logic [2:0] op, int unsigned letter,
                                           int unsigned pidx, bit eop);
        t_in_word w;
        w.opcode         = op;
        w.letter         = t_letter'(letter);
        w.pattern_index  = 3'(pidx);
        w.end_of_pattern = eop;
        return w;
    endfunction

    // Random receiver stall, drawn per result word.
    initial begin
        int unsigned hold;
        out_stall <= 1'b1;
        @(posedge clk);
        forever begin
            hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    // Compare each taken result word with the oldest prediction.
    always @(posedge clk) begin
        t_out_word exp_w;
        if (rst_n && out_valid && !out_stall) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                $error("result word with no prediction waiting");
                err_count++;
            end else begin
                exp_w = pending_results.pop_front();
                if (out_word.status !== exp_w.status) begin
                    $error("status exp %0d got %0d", exp_w.status, out_word.status);
                    err_count++;
                end
                if (out_word.current_node !== exp_w.current_node) begin
                    $error("current_node exp %0d got %0d", exp_w.current_node,
                           out_word.current_node);
                    err_count++;
                end
                if (out_word.found_patterns !== exp_w.found_patterns) begin
                    $error("found_patterns exp %h got %h", exp_w.found_patterns,
                           out_word.found_patterns);
                    err_count++;
                end
                if (out_word.node_total !== exp_w.node_total) begin
                    $error("node_total exp %0d got %0d", exp_w.node_total,
                           out_word.node_total);
                    err_count++;
                end
            end
        end
    end

    // Insert a whole pattern of the given letters.
    task automatic load_pattern(int unsigned letters[$], int unsigned pidx);
        for (int i = 0; i < letters.size(); i++)
            send_word(make_word(OP_INSERT, letters[i], pidx, i == letters.size() - 1));
    endtask

    task automatic scan_text(int unsigned letters[$]);
        foreach (letters[i]) send_word(make_word(OP_SCAN, letters[i], 0, 0));
    endtask

    // Directed: classic overlapping patterns, letter extremes, odd opcodes.
    task automatic test_directed();
        send_word(make_word(OP_SCAN, 0, 0, 0));             // scan before build
        load_pattern('{7, 4}, 0);                           // "he"
        load_pattern('{18, 7, 4}, 1);                       // "she"
        load_pattern('{7, 8, 18}, 7);                       // "his"
        load_pattern('{25}, 2);                             // "z"
        send_word(make_word(OP_INSERT, 31, 5, 1));          // out-of-alphabet insert
        send_word(make_word(OP_BUILD, 0, 0, 0));
        scan_text('{18, 7, 4, 31, 25});                     // includes out-of-alphabet scan
        send_word(make_word(OP_RESTART, 0, 0, 0));
        send_word(make_word(3'd7, 31, 7, 1));               // unused opcode
        send_word(make_word(3'd5, 0, 0, 0));
        send_word(make_word(OP_INSERT, 0, 3, 0));           // insert after build
        send_word(make_word(OP_SCAN, 7, 0, 0));
        send_word(make_word(OP_CLEAR, 0, 0, 0));
    endtask

    // Fill the node table and push past it to hit the full status.
    // Each 13-letter pattern repeats its own first letter, so every letter needs a new node.
    task automatic test_table_full();
        for (int n = 0; n < 140; n++)
            send_word(make_word(OP_INSERT, (n / 13) % ALPHABET, 4, (n % 13) == 12));
        send_word(make_word(OP_INSERT, 3, 6, 1));
        send_word(make_word(OP_BUILD, 0, 0, 0));
        for (int n = 0; n < 20; n++) send_word(make_word(OP_SCAN, $urandom_range(0, 25), 0, 0));
        send_word(make_word(OP_CLEAR, 0, 0, 0));
    endtask

    // Random sessions: load patterns over a small or the full alphabet, build, scan text.
    task automatic test_random(int unsigned target);
        int unsigned sent, npat, plen, alpha, r;
        int unsigned pat[$];
        sent = 0;
        while (sent < target) begin
            alpha = $urandom_range(2, 4) == 2 ? 26 : $urandom_range(2, 5);
            npat  = $urandom_range(1, 8);
            for (int p = 0; p < npat; p++) begin
                pat.delete();
                plen = $urandom_range(1, 5);
                for (int k = 0; k < plen; k++) pat = {pat, $urandom_range(0, alpha - 1)};
                load_pattern(pat, $urandom_range(0, 7));
                sent += plen;
            end
            send_word(make_word(OP_BUILD, 0, 0, 0));
            repeat ($urandom_range(10, 40)) begin
                r = $urandom_range(0, 99);
                if (r < 85)
                    send_word(make_word(OP_SCAN, $urandom_range(0, alpha - 1), 0, 0));
                else if (r < 90)
                    send_word(make_word(OP_SCAN, $urandom_range(0, 31), $urandom_range(0, 7),
                                        $urandom_range(0, 1)));
                else if (r < 95)
                    send_word(make_word(OP_RESTART, 0, 0, 0));
                else
                    send_word(make_word(3'($urandom_range(5, 7)), $urandom_range(0, 31),
                                        $urandom_range(0, 7), $urandom_range(0, 1)));
                sent++;
            end
            if ($urandom_range(0, 3) == 0) begin
                send_word(make_word(OP_INSERT, $urandom_range(0, 31), $urandom_range(0, 7),
                                    $urandom_range(0, 1)));
                send_word(make_word(OP_SCAN, $urandom_range(0, 25), 0, 0));
                sent += 2;
            end
            send_word(make_word(OP_CLEAR, 0, 0, 0));
            sent++;
        end
    endtask

    initial begin
        int unsigned drain;
        clear_model();
        err_count    = 0;
        cycle_count  = 0;
        results_seen = 0;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_word  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_table_full();
        test_random(850);
        in_valid <= 1'b0;

        // Drain outstanding results, then idle a little.
        drain = 0;
        while (pending_results.size() != 0 && drain < 200000) begin
            @(posedge clk);
            drain++;
        end
        repeat (50) @(posedge clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("** multi_pattern_automaton_unit: PASSED **");
        end else begin
            $display("** multi_pattern_automaton_unit: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire

### sim.f
+incdir+design
design/mpa_pkg.sv
design/mpa_ram.sv
design/mpa_seq.sv
design/multi_pattern_automaton_unit.sv
design/mpa_checker.sv
verif/tb_multi_pattern_automaton_unit.sv
